// ----- rtl/core/lsmm_pkg.sv -----
package lsmm_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t NEG_ONE = '1;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    COP_HOLD,
    COP_PUSH,
    COP_POP,
    COP_TAG,
    COP_SWAP,
    COP_FIX
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              parity;
    word_t             push_value;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

  // One stack slot: the entry, its sort tag during reversal, and the
  // largest and smallest entries from this slot down to the bottom.
  typedef struct packed {
    word_t             val;
    logic [IDX_W-1:0]  tag;
    word_t             mx;
    word_t             mn;
  } cell_t;

  typedef struct packed {
    word_t             popped_value;
    word_t             top_value;
    word_t             max_value;
    word_t             min_value;
    logic [CNT_W-1:0]  entry_count;
    logic [1:0]        status;
  } result_t;

  function automatic word_t word_max(input word_t a, input word_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic word_t word_min(input word_t a, input word_t b);
    return (b < a) ? b : a;
  endfunction

endpackage

// ----- rtl/core/lsmm_cell.sv -----
// One slot of the stack chain. Slot 0 is the top of the stack.
module lsmm_cell (
  input  logic                          clk,
  input  lsmm_pkg::cell_ctrl_t          ctrl,
  input  logic [lsmm_pkg::IDX_W-1:0]    cell_idx,
  input  lsmm_pkg::cell_t               up_cell,
  input  lsmm_pkg::cell_t               lo_cell,
  output lsmm_pkg::cell_t               cell_out
);

  lsmm_pkg::cell_t              cell_r;
  lsmm_pkg::cell_t              cell_nxt;
  logic [lsmm_pkg::CNT_W-1:0]   pos;
  logic [lsmm_pkg::CNT_W-1:0]   pos_below;
  logic                         has_below;
  logic                         in_stack;
  logic                         is_first;
  logic                         upper_member;

  assign pos          = lsmm_pkg::CNT_W'(cell_idx);
  assign pos_below    = pos + lsmm_pkg::CNT_W'(1);
  assign has_below    = pos_below < ctrl.count;
  assign in_stack     = pos < ctrl.count;
  assign is_first     = (cell_idx == '0);
  assign upper_member = (cell_idx[0] == ctrl.parity);

  always_comb begin
    cell_nxt = cell_r;
    case (ctrl.op)
      lsmm_pkg::COP_PUSH: begin
        if (is_first) begin
          cell_nxt.val = ctrl.push_value;
          if (ctrl.count == '0) begin
            cell_nxt.mx = ctrl.push_value;
            cell_nxt.mn = ctrl.push_value;
          end else begin
            cell_nxt.mx = lsmm_pkg::word_max(ctrl.push_value, cell_r.mx);
            cell_nxt.mn = lsmm_pkg::word_min(ctrl.push_value, cell_r.mn);
          end
        end else begin
          cell_nxt = up_cell;
        end
      end
      lsmm_pkg::COP_POP: begin
        cell_nxt = lo_cell;
      end
      lsmm_pkg::COP_TAG: begin
        cell_nxt.tag = cell_idx;
      end
      lsmm_pkg::COP_SWAP: begin
        // Odd-even transposition: the pair is (this, below) when the slot
        // parity matches the round, otherwise (above, this).
        if (upper_member) begin
          if (has_below && (cell_r.tag < lo_cell.tag)) begin
            cell_nxt.val = lo_cell.val;
            cell_nxt.tag = lo_cell.tag;
          end
        end else if (!is_first && in_stack && (up_cell.tag < cell_r.tag)) begin
          cell_nxt.val = up_cell.val;
          cell_nxt.tag = up_cell.tag;
        end
      end
      lsmm_pkg::COP_FIX: begin
        if (has_below) begin
          cell_nxt.mx = lsmm_pkg::word_max(cell_r.val, lo_cell.mx);
          cell_nxt.mn = lsmm_pkg::word_min(cell_r.val, lo_cell.mn);
        end else begin
          cell_nxt.mx = cell_r.val;
          cell_nxt.mn = cell_r.val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule

// ----- rtl/core/lsmm_obuf.sv -----
// Two-deep result buffer: an output register with a skid register behind it.
module lsmm_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 enq,
  input  lsmm_pkg::result_t    enq_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output lsmm_pkg::result_t    out_data,
  output logic                 skid_full
);

  lsmm_pkg::result_t  main_r;
  lsmm_pkg::result_t  main_nxt;
  lsmm_pkg::result_t  skid_r;
  lsmm_pkg::result_t  skid_nxt;
  logic               main_v_r;
  logic               main_v_nxt;
  logic               skid_v_r;
  logic               skid_v_nxt;
  logic               fire;

  assign fire = main_v_r & out_ready;

  always_comb begin
    main_nxt   = main_r;
    main_v_nxt = main_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (fire) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = 1'b0;
      end
    end
    if (enq) begin
      if (!main_v_nxt) begin
        main_nxt   = enq_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = enq_data;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;
  assign skid_full = skid_v_r;

endmodule

// ----- rtl/core/lifo_stack_min_max.sv -----
// Bounded LIFO stack of 64 signed 32-bit words that reports, after every
// item, the popped word, the top entry, the largest and smallest entries, the
// entry count and a status (0 ok, 1 pop on an empty stack, 2 push dropped
// because the stack is full). On an empty stack the popped, top, max and min
// words read as -1. The stack is a chain of cells with the top in cell 0;
// each cell also keeps the max and min of itself and every cell below it, so
// push, pop and no-op items queue their result in the cycle they are taken,
// and a new item can be taken as long as the skid register is not full. A
// reverse on a stack of n >= 2 entries holds off the next item until it is
// done: one step tags every cell with its position, n odd-even
// transposition rounds between neighboring cells turn the order over, the
// max/min values ripple up from the bottom again, and a last step queues the
// item's result. Reverse on zero or one entry moves nothing and queues its
// result at once. Results sit in an output register with a skid register
// behind it, so an item is still taken while one result waits at the output.
module lifo_stack_min_max (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_action,
  input  logic signed [31:0]                  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  out_popped_value,
  output logic signed [31:0]                  out_top_value,
  output logic signed [31:0]                  out_max_value,
  output logic signed [31:0]                  out_min_value,
  output logic [lsmm_pkg::CNT_W-1:0]          out_entry_count,
  output logic [1:0]                          out_status
);

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_REV  = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  localparam int CNT_W = lsmm_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWAP,
    ST_FIX,
    ST_DONE
  } state_t;

  state_t                 state_r;
  state_t                 state_nxt;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [CNT_W-1:0]       rnd_r;
  logic [CNT_W-1:0]       rnd_nxt;
  logic [CNT_W-1:0]       last_rnd;

  lsmm_pkg::cell_ctrl_t   ctrl;
  lsmm_pkg::cell_t        cells [lsmm_pkg::STACK_DEPTH];
  lsmm_pkg::cell_t        c0;
  lsmm_pkg::cell_t        c1;

  lsmm_pkg::result_t      res;
  lsmm_pkg::result_t      out_data;
  logic                   enq;
  logic                   skid_full;
  logic                   in_fire;

  assign in_ready = (state_r == ST_IDLE) && !skid_full;
  assign in_fire  = in_valid && in_ready;
  assign c0       = cells[0];
  assign c1       = cells[1];
  assign last_rnd = count_r - CNT_W'(1);

  // Cell chain. Each cell sees its neighbors above and below; the ends
  // see themselves in place of the missing neighbor.
  for (genvar g = 0; g < lsmm_pkg::STACK_DEPTH; g++) begin : g_cell
    lsmm_pkg::cell_t up_c;
    lsmm_pkg::cell_t lo_c;
    if (g == 0) begin : g_top
      assign up_c = cells[g];
    end else begin : g_mid_up
      assign up_c = cells[g-1];
    end
    if (g == lsmm_pkg::STACK_DEPTH - 1) begin : g_bottom
      assign lo_c = cells[g];
    end else begin : g_mid_lo
      assign lo_c = cells[g+1];
    end
    lsmm_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cell_idx (lsmm_pkg::IDX_W'(g)),
      .up_cell  (up_c),
      .lo_cell  (lo_c),
      .cell_out (cells[g])
    );
  end

  // Sequencer and result formation.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rnd_nxt         = rnd_r;
    enq             = 1'b0;
    ctrl.op         = lsmm_pkg::COP_HOLD;
    ctrl.parity     = rnd_r[0];
    ctrl.push_value = in_value;
    ctrl.count      = count_r;

    // By default the result reflects the current stack unchanged.
    res.popped_value = lsmm_pkg::NEG_ONE;
    res.status       = STS_OK;
    if (count_r == '0) begin
      res.top_value = lsmm_pkg::NEG_ONE;
      res.max_value = lsmm_pkg::NEG_ONE;
      res.min_value = lsmm_pkg::NEG_ONE;
    end else begin
      res.top_value = c0.val;
      res.max_value = c0.mx;
      res.min_value = c0.mn;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          enq = 1'b1;
          case (in_action)
            ACT_PUSH: begin
              if (count_r == CNT_W'(lsmm_pkg::STACK_DEPTH)) begin
                res.status = STS_FULL;
              end else begin
                ctrl.op       = lsmm_pkg::COP_PUSH;
                count_nxt     = count_r + CNT_W'(1);
                res.top_value = in_value;
                if (count_r == '0) begin
                  res.max_value = in_value;
                  res.min_value = in_value;
                end else begin
                  res.max_value = lsmm_pkg::word_max(in_value, c0.mx);
                  res.min_value = lsmm_pkg::word_min(in_value, c0.mn);
                end
              end
            end
            ACT_POP: begin
              if (count_r == '0) begin
                res.status = STS_EMPTY;
              end else begin
                ctrl.op          = lsmm_pkg::COP_POP;
                count_nxt        = count_r - CNT_W'(1);
                res.popped_value = c0.val;
                if (count_r == CNT_W'(1)) begin
                  res.top_value = lsmm_pkg::NEG_ONE;
                  res.max_value = lsmm_pkg::NEG_ONE;
                  res.min_value = lsmm_pkg::NEG_ONE;
                end else begin
                  res.top_value = c1.val;
                  res.max_value = c1.mx;
                  res.min_value = c1.mn;
                end
              end
            end
            ACT_REV: begin
              // Zero or one entry: nothing moves, the result goes out now.
              if (count_r > CNT_W'(1)) begin
                enq       = 1'b0;
                ctrl.op   = lsmm_pkg::COP_TAG;
                state_nxt = ST_SWAP;
                rnd_nxt   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWAP: begin
        ctrl.op = lsmm_pkg::COP_SWAP;
        if (rnd_r == last_rnd) begin
          state_nxt = ST_FIX;
          rnd_nxt   = '0;
        end else begin
          rnd_nxt = rnd_r + CNT_W'(1);
        end
      end
      ST_FIX: begin
        ctrl.op = lsmm_pkg::COP_FIX;
        if (rnd_r == last_rnd) begin
          state_nxt = ST_DONE;
          rnd_nxt   = '0;
        end else begin
          rnd_nxt = rnd_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        // Cell 0 now holds the new top and the refreshed max and min.
        enq       = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.entry_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  lsmm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq       (enq),
    .enq_data  (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .skid_full (skid_full)
  );

  assign out_popped_value = out_data.popped_value;
  assign out_top_value    = out_data.top_value;
  assign out_max_value    = out_data.max_value;
  assign out_min_value    = out_data.min_value;
  assign out_entry_count  = out_data.entry_count;
  assign out_status       = out_data.status;

  // The entry count never exceeds the depth of the chain.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(lsmm_pkg::STACK_DEPTH))
    else $error("entry count exceeds stack depth");

  // A pop taken on a non-empty stack removes exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_action == ACT_POP) && (count_r != '0))
    |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not remove one entry");

  // While a reversal is in flight the entry count does not move.
  a_rev_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> $stable(count_r))
    else $error("entry count changed during reversal");

  // A finished reversal always queues its result.
  a_rev_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> enq)
    else $error("reversal finished without a result");

endmodule
